[hdl/apf_pkg.sv]
// Package: types, constants and state codes for the articulation point finder.
package apf_pkg;

  localparam int unsigned NODES = 64;
  localparam int unsigned SLOTS = 512;
  localparam int unsigned NW    = 6;
  localparam int unsigned EW    = 9;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] node_a;
    logic [5:0] node_b;
  } in_item_t;

  typedef struct packed {
    logic [5:0] point_node;
    logic       has_point;
    logic       last;
    logic       status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD2,
    ST_HCLR,
    ST_MCLR,
    ST_VISIT,
    ST_FETCH,
    ST_EDGE,
    ST_POP,
    ST_POP2,
    ST_SCAN,
    ST_EMPTY
  } state_t;

endpackage

[hdl/articulation_point_finder.sv]
// Articulation point finder: adjacency store, iterative DFS and result scan.
// Add: stores the edge both ways through ST_ADD2, ST_HCLR and ST_MCLR and strobes its
// result after ST_MCLR. Clear, nop and rejected items: result strobed the next cycle.
// Run: visits the root, descends into each unvisited neighbour, checks each visited one
// against low, returns to each parent and then scans the marked nodes. One item at a
// time; reset (rst_n low, synchronous) empties the graph, node_count 64; no stalls.
module articulation_point_finder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  apf_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output apf_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_node_count
);
  import apf_pkg::*;

  // Node record fields
  // [33:28] disc [27:22] low [21:15] parent(7) [14:13] tally [12:10] unused
  // cursor uses 10 bits: [9:0], value >= 512 means end
  localparam logic [6:0] PNONE = 7'h7F;
  localparam logic [9:0] NIL   = 10'h3FF;

  state_t state_r, state_nxt;
  logic [6:0]  ncount_r;
  logic [9:0]  used_r, used_nxt;
  logic [5:0]  a_r, b_r;
  logic [1:0]  act_r;
  logic [5:0]  cur_r, cur_nxt;
  logic [6:0]  time_r, time_nxt;
  logic [6:0]  idx_r, idx_nxt;
  logic [63:0] vis_r, vis_nxt, cut_r, cut_nxt;
  logic [63:0] hvalid_r, hvalid_nxt;
  logic        strobe_nxt;
  out_item_t   oitem_nxt;
  logic        any_r, any_nxt;

  // Adjacency memories
  logic [5:0]  dest_mem [SLOTS];
  logic [9:0]  next_mem [SLOTS];
  logic [9:0]  head_mem [NODES];
  logic        e_we;
  logic [8:0]  e_wa;
  logic [5:0]  e_wd_dest;
  logic [9:0]  e_wd_next;
  logic [8:0]  e_ra;
  logic [5:0]  e_rd_dest;
  logic [9:0]  e_rd_next;
  logic        h_we;
  logic [5:0]  h_wa, h_ra;
  logic [9:0]  h_wd, h_rd;

  always_ff @(posedge clk) begin
    if (e_we) begin
      dest_mem[e_wa] <= e_wd_dest;
      next_mem[e_wa] <= e_wd_next;
    end
    e_rd_dest <= dest_mem[e_ra];
    e_rd_next <= next_mem[e_ra];
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      head_mem[h_wa] <= h_wd;
    end
    h_rd <= head_mem[h_ra];
  end

  // Node record memory
  logic        n_we;
  logic [5:0]  n_wa, n_ra_a, n_ra_b;
  logic [33:0] n_wd, n_rd_a, n_rd_b;

  apf_nodemem u_nodemem (
    .clk     (clk),
    .we      (n_we),
    .waddr   (n_wa),
    .wdata   (n_wd),
    .raddr_a (n_ra_a),
    .raddr_b (n_ra_b),
    .rdata_a (n_rd_a),
    .rdata_b (n_rd_b)
  );

  // Limit check
  logic [6:0] lim;
  assign lim = (ncount_r > 7'd64) ? 7'd64 : ncount_r;

  // Head read honors valid bits (cleared entries read empty)
  logic [5:0] h_ra_r;
  logic [9:0] head_val;
  always_ff @(posedge clk) h_ra_r <= h_ra;
  assign head_val = hvalid_r[h_ra_r] ? h_rd : NIL;

  // Current node record and parent record fields
  logic [5:0] p_disc, p_low;
  logic [6:0] c_par, p_par;
  logic [1:0] p_tally;
  assign c_par   = n_rd_a[21:15];
  assign p_disc  = n_rd_b[33:28];
  assign p_low   = n_rd_b[27:22];
  assign p_par   = n_rd_b[21:15];
  assign p_tally = n_rd_b[14:13];

  // Parent fold on return: saturating child tally and merged low time
  logic [1:0] pop_tally;
  logic [5:0] pop_low;
  logic [5:0] crec_low;

  // Working copy of the current record, kept in registers across cycles
  logic [33:0] crec_r, crec_nxt;
  logic [5:0]  w_r, w_nxt;

  assign crec_low  = crec_r[27:22];
  assign pop_tally = (p_tally < 2'd3) ? p_tally + 2'd1 : p_tally;
  assign pop_low   = (crec_low < p_low) ? crec_low : p_low;

  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ncount_r   <= 7'd64;
      used_r     <= '0;
      hvalid_r   <= '0;
      vis_r      <= '0;
      cut_r      <= '0;
      any_r      <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      hvalid_r   <= hvalid_nxt;
      vis_r      <= vis_nxt;
      cut_r      <= cut_nxt;
      any_r      <= any_nxt;
      out_strobe <= strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        ncount_r <= cfg_node_count;
      end
    end
    out_item <= oitem_nxt;
    cur_r    <= cur_nxt;
    time_r   <= time_nxt;
    idx_r    <= idx_nxt;
    crec_r   <= crec_nxt;
    w_r      <= w_nxt;
    if (start && !busy) begin
      a_r   <= in_item.node_a;
      b_r   <= in_item.node_b;
      act_r <= in_item.action;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    used_nxt   = used_r;
    hvalid_nxt = hvalid_r;
    vis_nxt    = vis_r;
    cut_nxt    = cut_r;
    cur_nxt    = cur_r;
    time_nxt   = time_r;
    idx_nxt    = idx_r;
    crec_nxt   = crec_r;
    w_nxt      = w_r;
    any_nxt    = any_r;
    strobe_nxt = 1'b0;
    oitem_nxt  = '{point_node: 6'd0, has_point: 1'b0, last: 1'b1, status: 1'b0};
    e_we = 1'b0; e_wa = used_r[8:0]; e_wd_dest = b_r; e_wd_next = head_val;
    e_ra = crec_r[8:0];
    h_we = 1'b0; h_wa = a_r; h_wd = used_r; h_ra = a_r;
    n_we = 1'b0; n_wa = cur_r; n_wd = crec_r;
    n_ra_a = cur_r; n_ra_b = c_par[5:0];

    unique case (state_r)
      ST_IDLE: begin
        h_ra = in_item.node_a;
        if (start) begin
          unique case (action_t'(in_item.action))
            ACT_ADD: begin
              if ({1'b0, in_item.node_a} >= lim || {1'b0, in_item.node_b} >= lim ||
                  used_r > 10'd510) begin
                strobe_nxt = 1'b1;
                oitem_nxt.status = 1'b1;
              end else begin
                state_nxt = ST_ADD2;
              end
            end
            ACT_RUN: begin
              if ({1'b0, in_item.node_a} >= lim) begin
                strobe_nxt = 1'b1;
                oitem_nxt.status = 1'b1;
              end else begin
                vis_nxt   = '0;
                cut_nxt   = '0;
                time_nxt  = '0;
                cur_nxt   = in_item.node_a;
                crec_nxt[21:15] = PNONE;
                state_nxt = ST_VISIT;
              end
            end
            ACT_CLEAR: begin
              hvalid_nxt = '0;
              used_nxt   = '0;
              strobe_nxt = 1'b1;
            end
            default: strobe_nxt = 1'b1;
          endcase
        end
      end
      // head(a) now read; push a->b, then read head(b)
      ST_ADD2: begin
        e_we = 1'b1; e_wd_dest = b_r; e_wd_next = head_val;
        h_we = 1'b1; h_wa = a_r; h_wd = used_r;
        hvalid_nxt[a_r] = 1'b1;
        used_nxt = used_r + 10'd1;
        h_ra = b_r;
        state_nxt = ST_HCLR;
      end
      // Wait for head(b) read after head(a) write
      ST_HCLR: begin
        h_ra = b_r;
        state_nxt = ST_MCLR;
      end
      ST_MCLR: begin
        e_we = 1'b1; e_wd_dest = a_r; e_wd_next = head_val;
        h_we = 1'b1; h_wa = b_r; h_wd = used_r;
        hvalid_nxt[b_r] = 1'b1;
        used_nxt   = used_r + 10'd1;
        any_nxt    = 1'b0;
        strobe_nxt = 1'b1;
        state_nxt  = ST_IDLE;
      end
      // Visit cur: head(cur) available; write its record
      ST_VISIT: begin
        h_ra = cur_r;
        if (any_r) begin
          crec_nxt = {time_r[5:0], time_r[5:0], crec_r[21:15], 2'b00, 3'b000, head_val};
          n_we = 1'b1;
          n_wd = {time_r[5:0], time_r[5:0], crec_r[21:15], 2'b00, 3'b000, head_val};
          vis_nxt[cur_r] = 1'b1;
          time_nxt = time_r + 7'd1;
          any_nxt = 1'b0;
          state_nxt = ST_FETCH;
        end else begin
          any_nxt = 1'b1;
        end
      end
      // Issue adjacency read for the cursor; when exhausted, pop to the parent or scan at the root
      ST_FETCH: begin
        e_ra = crec_r[8:0];
        if (crec_r[9:0] < used_r) begin
          state_nxt = ST_EDGE;
        end else if (crec_r[21]) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
          any_nxt   = 1'b0;
        end else begin
          n_ra_b    = crec_r[20:15];
          state_nxt = ST_POP;
        end
      end
      // Adjacency data back: advance cursor, descend to an unvisited node or check a visited one
      ST_EDGE: begin
        crec_nxt[9:0] = e_rd_next;
        w_nxt = e_rd_dest;
        n_ra_b = e_rd_dest;
        if (!vis_r[e_rd_dest]) begin
          n_we = 1'b1;
          n_wd = {crec_r[33:10], e_rd_next};
          cur_nxt = e_rd_dest;
          crec_nxt[21:15] = {1'b0, cur_r};
          h_ra = e_rd_dest;
          any_nxt = 1'b0;
          state_nxt = ST_VISIT;
        end else begin
          state_nxt = ST_POP2;
        end
      end
      // Back edge: disc(w) read; compare against low(cur)
      ST_POP2: begin
        if ({1'b0, w_r} != crec_r[21:15] && n_rd_b[33:28] < crec_r[27:22]) begin
          crec_nxt[27:22] = n_rd_b[33:28];
        end
        state_nxt = ST_FETCH;
      end
      // Return to parent: parent record read; fold results and switch
      ST_POP: begin
        if (p_par == PNONE) begin
          if (pop_tally > 2'd1) cut_nxt[crec_r[20:15]] = 1'b1;
        end else if (p_disc <= crec_low) begin
          cut_nxt[crec_r[20:15]] = 1'b1;
        end
        n_we = 1'b1;
        n_wa = crec_r[20:15];
        n_wd = {n_rd_b[33:28], pop_low, n_rd_b[21:15], pop_tally, n_rd_b[12:0]};
        crec_nxt = {n_rd_b[33:28], pop_low, n_rd_b[21:15], pop_tally, n_rd_b[12:0]};
        cur_nxt  = crec_r[20:15];
        state_nxt = ST_FETCH;
      end
      // Emit marked nodes in ascending order, or an empty result when none is marked
      ST_SCAN: begin
        if (idx_r == 7'd64) begin
          if (!any_r) begin
            strobe_nxt = 1'b1;
          end
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 7'd1;
          if (cut_r[idx_r[5:0]]) begin
            strobe_nxt = 1'b1;
            any_nxt = 1'b1;
            oitem_nxt.point_node = idx_r[5:0];
            oitem_nxt.has_point  = 1'b1;
            oitem_nxt.last       = ((cut_r >> idx_r[5:0]) >> 1) == 64'd0;
          end
          if (((cut_r >> idx_r[5:0]) == 64'd0) && any_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

[hdl/apf_nodemem.sv]
// Per-node search memory: disc, low, parent, tally, cursor packed in one RAM.
module apf_nodemem (
  input  logic        clk,
  input  logic        we,
  input  logic [5:0]  waddr,
  input  logic [33:0] wdata,
  input  logic [5:0]  raddr_a,
  input  logic [5:0]  raddr_b,
  output logic [33:0] rdata_a,
  output logic [33:0] rdata_b
);
  logic [33:0] mem [64];

  // One write and two registered reads per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
